### rtl/core/dcs_pkg.sv
// Shared constants and types for the distance constraint solver.
// Depends on nothing; every other file of the block imports it.
package dcs_pkg;

  localparam int POS_W    = 32;
  localparam int MASS_W   = 32;
  localparam int LEN_W    = 31;
  localparam int STIFF_W  = 17;
  localparam int STRAIN_W = 32;
  localparam int CFG_W    = 32;

  localparam logic [STIFF_W-1:0]  STIFF_RESET  = 17'd65536;
  localparam logic [STRAIN_W-1:0] STRAIN_RESET = 32'd65536;

  // Stage numbers of the pipeline.
  localparam int ST_IN      = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_RAD     = 2;
  localparam int ST_ROOT    = 3;
  localparam int ROOT_STEPS = 33;
  localparam int W_STEPS    = 17;
  localparam int ST_EXT     = ST_ROOT + ROOT_STEPS;
  localparam int ST_PROD    = ST_EXT + 1;
  localparam int ST_NUM     = ST_PROD + 1;
  localparam int ST_QUO     = ST_NUM + 1;
  localparam int QUO_STEPS  = 34;
  localparam int ST_MUL     = ST_QUO + QUO_STEPS;
  localparam int ST_MAG     = ST_MUL + 1;
  localparam int ST_OUT     = ST_MAG + 1;
  localparam int DEPTH      = ST_OUT + 1;

  typedef enum logic [0:0] {
    REG_STIFFNESS    = 1'b0,
    REG_STRAIN_LIMIT = 1'b1
  } reg_index_t;

endpackage

### rtl/core/dcs_bar_if.sv
// Input channel of the distance constraint solver: one bar per transfer.
// Depends on dcs_pkg for the field widths.
interface dcs_bar_if import dcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  first_x;
  logic signed [POS_W-1:0]  first_y;
  logic signed [POS_W-1:0]  second_x;
  logic signed [POS_W-1:0]  second_y;
  logic [MASS_W-1:0]        first_mass;
  logic [MASS_W-1:0]        second_mass;
  logic                     first_pinned;
  logic                     second_pinned;
  logic [LEN_W-1:0]         rest_length;

  modport source (output valid, first_x, first_y, second_x, second_y, first_mass,
                  second_mass, first_pinned, second_pinned, rest_length, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, first_mass,
                second_mass, first_pinned, second_pinned, rest_length, output ready);
endinterface

### rtl/core/dcs_result_if.sv
// Output channel of the distance constraint solver: one corrected bar per transfer.
// Depends on dcs_pkg for the field widths.
interface dcs_result_if import dcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  new_first_x;
  logic signed [POS_W-1:0]  new_first_y;
  logic signed [POS_W-1:0]  new_second_x;
  logic signed [POS_W-1:0]  new_second_y;
  logic                     fractured;

  modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                  fractured, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                fractured, output ready);
endinterface

### rtl/core/distance_constraint_solver.sv
// Distance constraint solver: a deep pipeline correcting one bar per cycle unless stalled.
// Depends on dcs_pkg, dcs_bar_if and dcs_result_if.
//
//   channel   direction  handshake          payload
//   bar       in         valid/ready        two endpoints, masses, pinned flags, rest length
//   result    out        valid/ready        corrected endpoints and fracture flag
//   cfg       in         cfg_we only        cfg_index selects stiffness or the strain limit
//
// One bar enters per cycle while the output is not stalled; the pipeline depth is set by
// the 33 one-bit square root stages and the 34 one-bit quotient stages of the
// length-normalising divide. Reset is synchronous and clears the valid bits and loads
// the register defaults. When a result waits at the output the whole pipeline holds,
// so nothing is lost or repeated; bubbles move on freely while the output is empty or
// being taken.
module distance_constraint_solver import dcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  reg_index_t        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  dcs_bar_if.sink           bar,
  dcs_result_if.source      result
);

  // Everything a bar carries through the pipeline. Fields are filled in as the stages
  // reach them; unused fields fall away in synthesis.
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic               fix1;
    logic               fix2;
    logic [30:0]        r0;
    logic               nx;
    logic               ny;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [32:0]        msum;
    logic [48:0]        nmul;
    logic [64:0]        sqx;
    logic [64:0]        sqy;
    logic [65:0]        rad;
    logic [33:0]        srem;
    logic [32:0]        root;
    logic [32:0]        drem;
    logic [16:0]        wq;
    logic [33:0]        abs_e;
    logic               neg_e;
    logic [17:0]        wa;
    logic [17:0]        wb;
    logic [63:0]        frhs;
    logic               frac;
    logic [49:0]        pxh;
    logic [50:0]        pxl;
    logic [49:0]        pyh;
    logic [50:0]        pyl;
    logic [66:0]        numx;
    logic [66:0]        numy;
    logic [32:0]        qrx;
    logic [32:0]        qry;
    logic [33:0]        qx;
    logic [33:0]        qy;
    logic [7:0][34:0]   mp;
    logic [3:0][35:0]   mag;
    logic signed [31:0] o1x;
    logic signed [31:0] o1y;
    logic signed [31:0] o2x;
    logic signed [31:0] o2y;
  } stage_t;

  logic [STIFF_W-1:0]  stiffness;
  logic [STRAIN_W-1:0] strain_limit;
  stage_t              pipe      [0:DEPTH-1];
  stage_t              pipe_next [0:DEPTH-1];
  logic [DEPTH-1:0]    valid;
  logic                advance;

  // Clamp a wide signed sum to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sd2147483647;
    lo = -38'sd2147483648;
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // New coordinate: base plus or minus the magnitude, signed by the direction.
  function automatic logic signed [31:0] moved(input logic signed [31:0] base,
                                               input logic [35:0] m,
                                               input logic neg,
                                               input logic sub);
    logic signed [37:0] delta;
    delta = signed'({2'b00, m});
    if (neg ^ sub) delta = -delta;
    return sat32(38'(base) + delta);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness    <= STIFF_RESET;
      strain_limit <= STRAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STIFFNESS:    stiffness    <= cfg_wdata[STIFF_W-1:0];
        REG_STRAIN_LIMIT: strain_limit <= cfg_wdata[STRAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign advance      = !valid[DEPTH-1] || result.ready;
  assign bar.ready    = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[DEPTH-2:0], bar.valid};
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    if (k == ST_IN) begin : g_in
      // Capture the bar, take the differences, the mass sum and the stiffness-mass product.
      always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        pipe_next[k]      = '0;
        pipe_next[k].x1   = bar.first_x;
        pipe_next[k].y1   = bar.first_y;
        pipe_next[k].x2   = bar.second_x;
        pipe_next[k].y2   = bar.second_y;
        pipe_next[k].fix1 = bar.first_pinned;
        pipe_next[k].fix2 = bar.second_pinned;
        pipe_next[k].r0   = bar.rest_length;
        dx = 33'(bar.second_x) - 33'(bar.first_x);
        dy = 33'(bar.second_y) - 33'(bar.first_y);
        pipe_next[k].nx   = dx[32];
        pipe_next[k].ny   = dy[32];
        pipe_next[k].ax   = dx[32] ? 33'(-dx) : 33'(dx);
        pipe_next[k].ay   = dy[32] ? 33'(-dy) : 33'(dy);
        pipe_next[k].msum = {1'b0, bar.first_mass} + {1'b0, bar.second_mass};
        pipe_next[k].nmul = 49'(stiffness) * 49'(bar.second_mass);
      end
    end else if (k == ST_SQ) begin : g_sq
      always_comb begin
        pipe_next[k]     = pipe[k-1];
        pipe_next[k].sqx = 65'(pipe[k-1].ax) * 65'(pipe[k-1].ax);
        pipe_next[k].sqy = 65'(pipe[k-1].ay) * 65'(pipe[k-1].ay);
      end
    end else if (k == ST_RAD) begin : g_rad
      // Sum of squares, and the starting remainder of the weight divide.
      always_comb begin
        pipe_next[k]      = pipe[k-1];
        pipe_next[k].rad  = 66'(pipe[k-1].sqx) + 66'(pipe[k-1].sqy);
        pipe_next[k].srem = '0;
        pipe_next[k].root = '0;
        pipe_next[k].drem = {1'b0, pipe[k-1].nmul[48:17]};
        pipe_next[k].wq   = '0;
      end
    end else if (k >= ST_ROOT && k < ST_EXT) begin : g_root
      // One bit of the square root per stage; the first stages also produce one bit
      // of the mass-weighted stiffness share.
      always_comb begin
        logic [35:0] rem;
        logic [35:0] trial;
        logic [33:0] d;
        pipe_next[k] = pipe[k-1];
        rem   = {pipe[k-1].srem, pipe[k-1].rad[65:64]};
        trial = {1'b0, pipe[k-1].root, 2'b01};
        pipe_next[k].rad = {pipe[k-1].rad[63:0], 2'b00};
        if (rem >= trial) begin
          pipe_next[k].srem = 34'(rem - trial);
          pipe_next[k].root = {pipe[k-1].root[31:0], 1'b1};
        end else begin
          pipe_next[k].srem = rem[33:0];
          pipe_next[k].root = {pipe[k-1].root[31:0], 1'b0};
        end
        d = {pipe[k-1].drem, pipe[k-1].nmul[16]};
        if (k < ST_ROOT + W_STEPS) begin
          pipe_next[k].nmul = {pipe[k-1].nmul[47:0], 1'b0};
          if (d >= {1'b0, pipe[k-1].msum}) begin
            pipe_next[k].drem = 33'(d - {1'b0, pipe[k-1].msum});
            pipe_next[k].wq   = {pipe[k-1].wq[15:0], 1'b1};
          end else begin
            pipe_next[k].drem = d[32:0];
            pipe_next[k].wq   = {pipe[k-1].wq[15:0], 1'b0};
          end
        end
      end
    end else if (k == ST_EXT) begin : g_ext
      // Extension, the two endpoint weights and the fracture threshold.
      always_comb begin
        logic signed [34:0] ext;
        logic [16:0]        w1;
        logic [16:0]        w2;
        pipe_next[k] = pipe[k-1];
        ext = signed'(35'(pipe[k-1].root)) - signed'(35'(pipe[k-1].r0));
        pipe_next[k].neg_e = ext[34];
        pipe_next[k].abs_e = ext[34] ? 34'(-ext) : ext[33:0];
        w1 = (pipe[k-1].msum == '0) ? (stiffness >> 1) : pipe[k-1].wq;
        w2 = stiffness - w1;
        pipe_next[k].wa = pipe[k-1].fix2 ? {w1, 1'b0} : {1'b0, w1};
        pipe_next[k].wb = pipe[k-1].fix1 ? {w2, 1'b0} : {1'b0, w2};
        pipe_next[k].frhs = 64'({1'b0, strain_limit} + 33'd1) * 64'(pipe[k-1].r0);
      end
    end else if (k == ST_PROD) begin : g_prod
      always_comb begin
        pipe_next[k]      = pipe[k-1];
        pipe_next[k].pxh  = 50'(pipe[k-1].abs_e) * 50'(pipe[k-1].ax[32:17]);
        pipe_next[k].pxl  = 51'(pipe[k-1].abs_e) * 51'(pipe[k-1].ax[16:0]);
        pipe_next[k].pyh  = 50'(pipe[k-1].abs_e) * 50'(pipe[k-1].ay[32:17]);
        pipe_next[k].pyl  = 51'(pipe[k-1].abs_e) * 51'(pipe[k-1].ay[16:0]);
        pipe_next[k].frac = 64'({pipe[k-1].abs_e, 16'h0000}) >= pipe[k-1].frhs;
      end
    end else if (k == ST_NUM) begin : g_num
      always_comb begin
        logic [66:0] nx;
        logic [66:0] ny;
        pipe_next[k] = pipe[k-1];
        nx = (67'(pipe[k-1].pxh) << 17) + 67'(pipe[k-1].pxl);
        ny = (67'(pipe[k-1].pyh) << 17) + 67'(pipe[k-1].pyl);
        pipe_next[k].numx = nx;
        pipe_next[k].numy = ny;
        pipe_next[k].qrx  = nx[66:34];
        pipe_next[k].qry  = ny[66:34];
        pipe_next[k].qx   = '0;
        pipe_next[k].qy   = '0;
      end
    end else if (k >= ST_QUO && k < ST_MUL) begin : g_quo
      // One quotient bit per axis per stage of |E| * |c| / L.
      always_comb begin
        logic [33:0] dx;
        logic [33:0] dy;
        logic [33:0] len;
        pipe_next[k] = pipe[k-1];
        len = {1'b0, pipe[k-1].root};
        dx  = {pipe[k-1].qrx, pipe[k-1].numx[33]};
        dy  = {pipe[k-1].qry, pipe[k-1].numy[33]};
        pipe_next[k].numx = {pipe[k-1].numx[65:0], 1'b0};
        pipe_next[k].numy = {pipe[k-1].numy[65:0], 1'b0};
        if (dx >= len) begin
          pipe_next[k].qrx = 33'(dx - len);
          pipe_next[k].qx  = {pipe[k-1].qx[32:0], 1'b1};
        end else begin
          pipe_next[k].qrx = dx[32:0];
          pipe_next[k].qx  = {pipe[k-1].qx[32:0], 1'b0};
        end
        if (dy >= len) begin
          pipe_next[k].qry = 33'(dy - len);
          pipe_next[k].qy  = {pipe[k-1].qy[32:0], 1'b1};
        end else begin
          pipe_next[k].qry = dy[32:0];
          pipe_next[k].qy  = {pipe[k-1].qy[32:0], 1'b0};
        end
      end
    end else if (k == ST_MUL) begin : g_mul
      // Weight times quotient, split into upper and lower halves of the quotient.
      always_comb begin
        pipe_next[k]       = pipe[k-1];
        pipe_next[k].mp[0] = 35'(pipe[k-1].wa) * 35'(pipe[k-1].qx[33:17]);
        pipe_next[k].mp[1] = 35'(pipe[k-1].wa) * 35'(pipe[k-1].qx[16:0]);
        pipe_next[k].mp[2] = 35'(pipe[k-1].wa) * 35'(pipe[k-1].qy[33:17]);
        pipe_next[k].mp[3] = 35'(pipe[k-1].wa) * 35'(pipe[k-1].qy[16:0]);
        pipe_next[k].mp[4] = 35'(pipe[k-1].wb) * 35'(pipe[k-1].qx[33:17]);
        pipe_next[k].mp[5] = 35'(pipe[k-1].wb) * 35'(pipe[k-1].qx[16:0]);
        pipe_next[k].mp[6] = 35'(pipe[k-1].wb) * 35'(pipe[k-1].qy[33:17]);
        pipe_next[k].mp[7] = 35'(pipe[k-1].wb) * 35'(pipe[k-1].qy[16:0]);
      end
    end else if (k == ST_MAG) begin : g_mag
      always_comb begin
        logic [52:0] full;
        pipe_next[k] = pipe[k-1];
        for (int i = 0; i < 4; i++) begin
          full = (53'(pipe[k-1].mp[2*i]) << 17) + 53'(pipe[k-1].mp[2*i+1]);
          pipe_next[k].mag[i] = full[51:16];
        end
      end
    end else begin : g_out
      // Apply the moves to free endpoints of bars with nonzero length.
      always_comb begin
        logic move1;
        logic move2;
        logic negx;
        logic negy;
        pipe_next[k] = pipe[k-1];
        move1 = (pipe[k-1].root != '0) && !pipe[k-1].fix1;
        move2 = (pipe[k-1].root != '0) && !pipe[k-1].fix2;
        negx  = pipe[k-1].neg_e ^ pipe[k-1].nx;
        negy  = pipe[k-1].neg_e ^ pipe[k-1].ny;
        pipe_next[k].o1x = move1 ? moved(pipe[k-1].x1, pipe[k-1].mag[0], negx, 1'b0)
                                 : pipe[k-1].x1;
        pipe_next[k].o1y = move1 ? moved(pipe[k-1].y1, pipe[k-1].mag[1], negy, 1'b0)
                                 : pipe[k-1].y1;
        pipe_next[k].o2x = move2 ? moved(pipe[k-1].x2, pipe[k-1].mag[2], negx, 1'b1)
                                 : pipe[k-1].x2;
        pipe_next[k].o2y = move2 ? moved(pipe[k-1].y2, pipe[k-1].mag[3], negy, 1'b1)
                                 : pipe[k-1].y2;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign result.valid        = valid[DEPTH-1];
  assign result.new_first_x  = pipe[DEPTH-1].o1x;
  assign result.new_first_y  = pipe[DEPTH-1].o1y;
  assign result.new_second_x = pipe[DEPTH-1].o2x;
  assign result.new_second_y = pipe[DEPTH-1].o2y;
  assign result.fractured    = pipe[DEPTH-1].frac;

endmodule
